// ===== hw/rtl/mcsp_pkg.sv =====
// Shared types and constants for the multi-channel servo PWM core.
// No dependencies; used by multi_channel_servo_pwm_core.
`timescale 1ns / 1ps
`default_nettype none

package mcsp_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_SET_WIDTH = 3'd1,
    ACT_SET_GATE  = 3'd2,
    ACT_START     = 3'd3,
    ACT_STOP      = 3'd4
  } action_e;

  // Configuration register indexes
  localparam logic CFG_PERIOD_TICKS = 1'b0;
  localparam logic CFG_TICKS_PER_US = 1'b1;

  // Field widths
  localparam int unsigned ActW    = 3;
  localparam int unsigned ChanW   = 5;
  localparam int unsigned WidthW  = 16;
  localparam int unsigned TpuW    = 8;
  localparam int unsigned TickW   = 24;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned SyncW   = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned InDataW = 24;

  // Register reset values (timer clock over 150 Hz frame rate)
  localparam logic [PeriodW-1:0] PeriodReset = 32'd280000;
  localparam logic [TpuW-1:0]    TpuReset    = 8'd42;

  localparam int unsigned DefaultChannels = 18;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_channel_servo_pwm_core.sv =====
// Multi-channel servo PWM core with shadow width registers.
// Pipeline: the item register loads at the input transfer and the result register loads when
// the item in the stage fires, which a stalled output can hold off. Throughput: one item per
// cycle while the result side takes transfers; the state update and the parallel channel
// compares all sit in the single stage between those two registers. Reset: asynchronous,
// active low; all pins high, channels disabled, stopped.
// Depends on mcsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_servo_pwm_core #(
  parameter int unsigned CHANNELS = mcsp_pkg::DefaultChannels,
  localparam int unsigned OutDataW = ((CHANNELS + 1 + mcsp_pkg::SyncW + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [mcsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mcsp_pkg::CfgW-1:0]     cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [4:0] channel, [20:5] width_us, [21] gate_open
  input  wire logic [mcsp_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] action
  input  wire logic [mcsp_pkg::ActW-1:0]     s_axis_tuser,
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [CHANNELS-1:0] pin_levels, [CHANNELS] period_start,
  // [CHANNELS+32:CHANNELS+1] period_number
  output logic [OutDataW-1:0]                m_axis_tdata
);

  localparam int unsigned TickW   = mcsp_pkg::TickW;
  localparam int unsigned PeriodW = mcsp_pkg::PeriodW;
  localparam int unsigned SyncW   = mcsp_pkg::SyncW;
  localparam int unsigned ChanW   = mcsp_pkg::ChanW;
  localparam int unsigned WidthW  = mcsp_pkg::WidthW;
  localparam int unsigned TpuW    = mcsp_pkg::TpuW;

  // Configuration registers
  logic [PeriodW-1:0] period_q;
  logic [TpuW-1:0]    tpu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= mcsp_pkg::PeriodReset;
      tpu_q    <= mcsp_pkg::TpuReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcsp_pkg::CFG_PERIOD_TICKS: period_q <= cfg_data_i[PeriodW-1:0];
        mcsp_pkg::CFG_TICKS_PER_US: tpu_q    <= cfg_data_i[TpuW-1:0];
        default: ;
      endcase
    end
  end

  // Item register and handshake
  logic                item_vld_q;
  mcsp_pkg::action_e   act_q;
  logic [ChanW-1:0]    chan_q;
  logic [WidthW-1:0]   width_q;
  logic                gate_in_q;
  logic                out_vld_q;
  logic                advance;
  logic                stage_fire;

  assign advance       = !out_vld_q || m_axis_tready;
  assign stage_fire    = item_vld_q && advance;
  assign s_axis_tready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_q     <= mcsp_pkg::action_e'(s_axis_tuser);
      chan_q    <= s_axis_tdata[ChanW-1:0];
      width_q   <= s_axis_tdata[ChanW +: WidthW];
      gate_in_q <= s_axis_tdata[ChanW+WidthW];
    end
  end

  // Generator state
  logic [PeriodW-1:0]  cnt_q, cnt_d;
  logic [CHANNELS-1:0] shd_vld_q, shd_vld_d;
  logic [CHANNELS-1:0] act_vld_q, act_vld_d;
  logic [CHANNELS-1:0] pins_q, pins_d;
  logic                gate_q, gate_d;
  logic                run_q, run_d;
  logic                started_q, started_d;
  logic [SyncW-1:0]    sync_cnt_q, sync_cnt_d;
  logic [TickW-1:0]    shd_ticks_q [CHANNELS];
  logic [TickW-1:0]    act_ticks_q [CHANNELS];

  logic                tick_wrap;
  logic                load_active;
  logic [CHANNELS-1:0] shd_wr;
  logic [TickW-1:0]    width_ticks;

  // Width in ticks; 16 x 8 bits fits the 24-bit compare exactly
  assign width_ticks = TickW'(width_q) * TickW'(tpu_q);

  // Next-state logic for the item in the stage
  always_comb begin
    logic [PeriodW:0]   cnt_inc;
    logic [TickW-1:0]   cmp_ticks;
    cnt_inc     = {1'b0, cnt_q} + (PeriodW+1)'(1);
    cmp_ticks   = '0;
    tick_wrap   = 1'b0;
    load_active = 1'b0;
    shd_wr      = '0;
    cnt_d       = cnt_q;
    shd_vld_d   = shd_vld_q;
    act_vld_d   = act_vld_q;
    pins_d      = pins_q;
    gate_d      = gate_q;
    run_d       = run_q;
    started_d   = started_q;
    sync_cnt_d  = sync_cnt_q;
    case (act_q)
      mcsp_pkg::ACT_TICK: begin
        if (run_q) begin
          if (cnt_inc >= {1'b0, period_q}) begin
            // period wrap: all pins high, optional shadow load
            tick_wrap   = 1'b1;
            cnt_d       = '0;
            pins_d      = '1;
            sync_cnt_d  = sync_cnt_q + SyncW'(1);
            load_active = gate_q;
            if (gate_q) begin
              act_vld_d = shd_vld_q;
            end
            started_d = 1'b1;
          end else begin
            cnt_d = cnt_inc[PeriodW-1:0];
          end
          // parallel compares against the new counter value
          if (started_d) begin
            for (int c = 0; c < CHANNELS; c++) begin
              cmp_ticks = load_active ? shd_ticks_q[c] : act_ticks_q[c];
              if (act_vld_d[c] && ({{(PeriodW-TickW){1'b0}}, cmp_ticks} == cnt_d)) begin
                pins_d[c] = 1'b0;
              end
            end
          end
        end
      end
      mcsp_pkg::ACT_SET_WIDTH: begin
        // out-of-range channels match no entry and are dropped
        for (int c = 0; c < CHANNELS; c++) begin
          if (chan_q == ChanW'(c)) begin
            shd_wr[c] = 1'b1;
          end
        end
        shd_vld_d = shd_vld_q | shd_wr;
      end
      mcsp_pkg::ACT_SET_GATE: begin
        gate_d = gate_in_q;
      end
      mcsp_pkg::ACT_START: begin
        run_d     = 1'b1;
        cnt_d     = '0;
        gate_d    = 1'b1;
        started_d = 1'b0;
      end
      mcsp_pkg::ACT_STOP: begin
        run_d     = 1'b0;
        started_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      shd_vld_q  <= '0;
      act_vld_q  <= '0;
      pins_q     <= '1;
      gate_q     <= 1'b0;
      run_q      <= 1'b0;
      started_q  <= 1'b0;
      sync_cnt_q <= '0;
    end else if (stage_fire) begin
      cnt_q      <= cnt_d;
      shd_vld_q  <= shd_vld_d;
      act_vld_q  <= act_vld_d;
      pins_q     <= pins_d;
      gate_q     <= gate_d;
      run_q      <= run_d;
      started_q  <= started_d;
      sync_cnt_q <= sync_cnt_d;
    end
  end

  // Shadow and active compare stores; entries are qualified by their valid bits
  always_ff @(posedge clk_i) begin
    if (stage_fire) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (shd_wr[c]) begin
          shd_ticks_q[c] <= width_ticks;
        end
        if (load_active) begin
          act_ticks_q[c] <= shd_ticks_q[c];
        end
      end
    end
  end

  // Result register
  logic [CHANNELS-1:0] out_pins_q;
  logic                out_start_q;
  logic [SyncW-1:0]    out_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire) begin
      out_pins_q  <= pins_d;
      out_start_q <= tick_wrap;
      out_num_q   <= sync_cnt_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'({out_num_q, out_start_q, out_pins_q});

  // Checks
  a_sync_only_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stage_fire && tick_wrap) |=> $stable(sync_cnt_q))
    else $error("sync count moved without a period wrap");

  a_wrap_clears_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_fire && tick_wrap) |=> (cnt_q == '0))
    else $error("period counter not cleared on wrap");

  a_started_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> !started_q)
    else $error("channel compares active while stopped");

  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && !advance) |=> (item_vld_q && $stable(act_q) && $stable(chan_q)
                                  && $stable(width_q)))
    else $error("stalled item lost from the item register");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for multi_channel_servo_pwm_core: sends tick, width, gate, start and
// stop transfers in random bursts against random output stalls, and checks every output transfer
// against an in-bench model of the counter, shadow/active compares and pins. Needs mcsp_pkg.
`timescale 1ns / 1ps

module tb_top;
  import mcsp_pkg::*;

  localparam int unsigned NCH       = DefaultChannels;
  localparam int unsigned OUTW      = ((NCH + 1 + SyncW + 7) / 8) * 8;
  localparam int unsigned MAX_SHOWN = 10;

  // kinds outside the defined set, the block must ignore them
  localparam logic [ActW-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ActW-1:0] ACT_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [NCH-1:0]   pins;
    logic             start;
    logic [SyncW-1:0] number;
  } pwm_out_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic [ActW-1:0]    s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUTW-1:0]    m_axis_tdata;

  // model of the generator state and its timing registers
  logic [PeriodW-1:0] mdl_period;
  logic [TpuW-1:0]    mdl_tpu;
  logic [PeriodW-1:0] mdl_count;
  logic [TickW-1:0]   mdl_shadow [NCH];
  logic [TickW-1:0]   mdl_active [NCH];
  logic [NCH-1:0]     mdl_shadow_en;
  logic [NCH-1:0]     mdl_active_en;
  logic [NCH-1:0]     mdl_pins;
  logic               mdl_gate;
  logic               mdl_run;
  logic               mdl_cmp_on;
  logic [SyncW-1:0]   mdl_sync;

  pwm_out_t    pwm_out_q [$];
  int unsigned error_cnt = 0;

  // sender burst control and receiver stall control
  int          burst_left = 0;
  bit          sender_idles = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cyc = 0;
  logic [7:0]  stall_pattern = 8'hFF;

  multi_channel_servo_pwm_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void reset_model();
    mdl_period    = PeriodReset;
    mdl_tpu       = TpuReset;
    mdl_count     = '0;
    mdl_shadow_en = '0;
    mdl_active_en = '0;
    mdl_pins      = '1;
    mdl_gate      = 1'b0;
    mdl_run       = 1'b0;
    mdl_cmp_on    = 1'b0;
    mdl_sync      = '0;
    for (int c = 0; c < NCH; c++) begin
      mdl_shadow[c] = '0;
      mdl_active[c] = '0;
    end
  endfunction

  // advance the model by one item and return the output it should produce
  function automatic pwm_out_t predict_pwm_output(logic [ActW-1:0] act, logic [ChanW-1:0] ch,
                                                  logic [WidthW-1:0] w, logic gate);
    pwm_out_t res;
    logic     wrapped;
    wrapped = 1'b0;
    case (act)
      ACT_TICK: begin
        if (mdl_run) begin
          if (({1'b0, mdl_count} + 33'd1) >= {1'b0, mdl_period}) begin
            mdl_count = '0;
            mdl_pins  = '1;
            mdl_sync  = mdl_sync + 1'b1;
            if (mdl_gate) begin
              mdl_active    = mdl_shadow;
              mdl_active_en = mdl_shadow_en;
            end
            mdl_cmp_on = 1'b1;
            wrapped    = 1'b1;
          end else begin
            mdl_count = mdl_count + 1'b1;
          end
          // compare applies on the wrap tick too, so a zero width drops at once
          if (mdl_cmp_on) begin
            for (int c = 0; c < NCH; c++) begin
              if (mdl_active_en[c] && {{(PeriodW-TickW){1'b0}}, mdl_active[c]} == mdl_count)
                mdl_pins[c] = 1'b0;
            end
          end
        end
      end
      ACT_SET_WIDTH: begin
        if (ch < NCH) begin
          mdl_shadow[ch]    = w * mdl_tpu;
          mdl_shadow_en[ch] = 1'b1;
        end
      end
      ACT_SET_GATE: mdl_gate = gate;
      ACT_START: begin
        mdl_run    = 1'b1;
        mdl_count  = '0;
        mdl_gate   = 1'b1;
        mdl_cmp_on = 1'b0;
      end
      ACT_STOP: begin
        mdl_run    = 1'b0;
        mdl_cmp_on = 1'b0;
      end
      default: ;
    endcase
    res.pins   = mdl_pins;
    res.start  = wrapped;
    res.number = mdl_sync;
    return res;
  endfunction

  // bus monitor: register writes and input transfers feed the model, output transfers are checked
  always @(posedge clk_i) begin : pwm_monitor
    pwm_out_t got;
    pwm_out_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PERIOD_TICKS) mdl_period = cfg_data_i;
        else mdl_tpu = cfg_data_i[TpuW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        pwm_out_q.push_back(predict_pwm_output(s_axis_tuser, s_axis_tdata[ChanW-1:0],
                                               s_axis_tdata[ChanW+WidthW-1:ChanW],
                                               s_axis_tdata[ChanW+WidthW]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.pins   = m_axis_tdata[NCH-1:0];
        got.start  = m_axis_tdata[NCH];
        got.number = m_axis_tdata[NCH+SyncW:NCH+1];
        if (pwm_out_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_SHOWN)
            $display("%0t: output transfer with none expected: pins %h start %b period %0d",
                     $realtime, got.pins, got.start, got.number);
        end else begin
          want = pwm_out_q.pop_front();
          if (got.pins !== want.pins || got.start !== want.start
              || got.number !== want.number) begin
            error_cnt++;
            if (error_cnt <= MAX_SHOWN)
              $display("%0t: mismatch pins %h/%h start %b/%b period %0d/%0d (exp/got)",
                       $realtime, want.pins, got.pins, want.start, got.start,
                       want.number, got.number);
          end
        end
      end
    end
  end

  // output side: random stall pattern, re-drawn from the random source, or a long hold on request
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (stall_cyc % 64 == 0)
      stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= stall_pattern[stall_cyc % 8];
    end
    stall_cyc++;
  end

  // one input transfer; bursts of random length with random gaps in between while sender_idles is set
  task automatic send_item(logic [ActW-1:0] act, logic [ChanW-1:0] ch, logic [WidthW-1:0] w,
                           logic gate);
    int gap;
    if (burst_left == 0) begin
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(InDataW-ChanW-WidthW-1){1'b0}}, gate, w, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // drop valid and wait until every expected output has arrived
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pwm_out_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_timing(logic [PeriodW-1:0] period, logic [TpuW-1:0] tpu);
    write_cfg(CFG_PERIOD_TICKS, period);
    write_cfg(CFG_TICKS_PER_US, {{(CfgW-TpuW){1'b0}}, tpu});
  endtask

  // mostly ticks and width writes sized to hit the period, plus some noise
  task automatic send_random_item(logic [PeriodW-1:0] period, logic [TpuW-1:0] tpu);
    int unsigned       pick;
    int unsigned       span;
    logic [ChanW-1:0]  ch;
    logic [WidthW-1:0] w;
    pick = $urandom_range(0, 99);
    span = period / ((tpu == 0) ? 1 : tpu);
    if (span > 65533) span = 65533;
    span += 2;
    ch = ($urandom_range(0, 9) == 0) ? ChanW'($urandom) : ChanW'($urandom_range(0, NCH - 1));
    w  = ($urandom_range(0, 3) == 0) ? WidthW'($urandom) : WidthW'($urandom_range(0, span));
    if (pick < 55)      send_item(ACT_TICK, ch, w, pick[0]);
    else if (pick < 75) send_item(ACT_SET_WIDTH, ch, w, pick[1]);
    else if (pick < 84) send_item(ACT_SET_GATE, ch, w, $urandom_range(0, 1));
    else if (pick < 88) send_item(ACT_START, ch, w, pick[0]);
    else if (pick < 91) send_item(ACT_STOP, ch, w, pick[0]);
    else if (pick < 94)
      send_item(ActW'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)), ch, w, 1'b1);
    else                send_item(ACT_TICK, ch, w, 1'b1);
  endtask

  // reset timing: stopped ticks, ignored kinds, out-of-range channel, width past the period
  task automatic test_reset_state();
    send_item(ACT_TICK, '0, '0, 1'b0);
    send_item(ACT_UNUSED_FIRST, '1, '1, 1'b1);
    send_item(ACT_SET_WIDTH, '1, '1, 1'b0);
    send_item(ACT_SET_WIDTH, '0, '1, 1'b0);
    send_item(ACT_START, '0, '0, 1'b0);
    send_item(ACT_TICK, '0, '0, 1'b0);
    send_item(ACT_STOP, '0, '0, 1'b0);
    send_item(ACT_UNUSED_LAST, '0, '0, 1'b0);
    settle();
  endtask

  // short period: zero width drops on the wrap, mid width, width beyond the period, out-of-range channel
  task automatic test_wrap_compare();
    set_timing(32'd4, 8'd1);
    send_item(ACT_SET_WIDTH, 5'd0, 16'd0, 1'b0);
    send_item(ACT_SET_WIDTH, 5'd1, 16'd2, 1'b0);
    send_item(ACT_SET_WIDTH, 5'd2, 16'd9, 1'b0);
    send_item(ACT_SET_WIDTH, 5'd18, 16'd1, 1'b0);
    send_item(ACT_SET_GATE, '0, '0, 1'b0);
    send_item(ACT_START, '0, '0, 1'b0);
    repeat (6) send_item(ACT_TICK, '0, '0, 1'b0);
    settle();
  endtask

  // zero period with zero ticks per us, then the widest period and conversion factor
  task automatic test_extreme_timing();
    set_timing('0, '0);
    send_item(ACT_SET_WIDTH, 5'd5, 16'd1234, 1'b0);
    send_item(ACT_START, '0, '0, 1'b0);
    repeat (2) send_item(ACT_TICK, '0, '0, 1'b0);
    settle();
    set_timing('1, '1);
    send_item(ACT_SET_WIDTH, 5'd16, '1, 1'b0);
    send_item(ACT_START, '0, '0, 1'b0);
    send_item(ACT_TICK, '0, '0, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [PeriodW-1:0] period;
    logic [TpuW-1:0]    tpu;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin period = 32'd1; tpu = 8'd1; end
        1: begin period = $urandom_range(2, 12); tpu = 8'd1; end
        2: begin period = $urandom_range(8, 40); tpu = $urandom_range(1, 4); end
        3: begin period = '1; tpu = '1; end
        4: begin period = $urandom_range(3, 30); tpu = 8'd1; end
        5: begin period = '0; tpu = '0; end
        6: begin period = $urandom_range(20, 60); tpu = $urandom_range(1, 255); end
        default: begin period = $urandom_range(1, 50); tpu = $urandom_range(1, 8); end
      endcase
      // one phase runs with no input gaps at all
      sender_idles = (ph != 4);
      set_timing(period, tpu);
      send_item(ACT_START, '0, '0, 1'b0);
      repeat (140) send_random_item(period, tpu);
      settle();
    end
    sender_idles = 1'b1;
  endtask

  // long output hold while the input keeps offering, so the core fills and stalls
  task automatic test_output_backpressure();
    set_timing(32'd6, 8'd1);
    send_item(ACT_START, '0, '0, 1'b0);
    hold_req     = 200;
    sender_idles = 1'b0;
    repeat (60) send_random_item(32'd6, 8'd1);
    sender_idles = 1'b1;
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    reset_model();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_wrap_compare();
    test_extreme_timing();
    test_random_traffic();
    test_output_backpressure();

    // catch any stray output transfer, then count expectations never met
    repeat (10) @(posedge clk_i);
    error_cnt += pwm_out_q.size();
    if (error_cnt == 0) begin
      $display("** multi_channel_servo_pwm_core: PASSED **");
    end else begin
      $display("** multi_channel_servo_pwm_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("** multi_channel_servo_pwm_core: FAILED **");
    $finish;
  end

endmodule
